// ===== rtl/fldc_pkg.sv =====
`timescale 1ns / 1ps

package fldc_pkg;

  // default number of thermal levels
  localparam int LEVEL_COUNT_DEF = 12;

  // field widths
  localparam int LVL_W      = 4;
  localparam int TEMP_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int STEP_W     = 4;
  localparam int MODE_W     = 2;
  localparam int CH_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // internal arithmetic widths: level thresholds and offset products
  localparam int THR_W = 12;
  localparam int ACC_W = 16;

  // fixed thresholds of the bottom and top levels
  localparam logic signed [THR_W-1:0] ON_LVL0  = THR_W'(-35);
  localparam logic signed [THR_W-1:0] OFF_LVL0 = THR_W'(-128);
  localparam logic signed [THR_W-1:0] OFF_LVL1 = THR_W'(-40);
  localparam logic signed [THR_W-1:0] ON_TOP   = THR_W'(127);

  // reciprocal of ten for small operands: floor(m/10) = (m*205) >> 11
  localparam int RECIP_W   = 8;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 8'd205;
  localparam int PROD_W    = 17;

  // reset values of the state
  localparam logic [LVL_W-1:0]  LEVEL_RST = 4'd1;
  localparam logic [TEMP_W-1:0] PREV_RST  = 8'd127;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_TOP    = 3'd0,
    CFG_TEMP_BASE   = 3'd1,
    CFG_DUTY_FULL   = 3'd2,
    CFG_DUTY_FLOOR  = 3'd3,
    CFG_ACTIVE_LOW  = 3'd4,
    CFG_FAN_CHANNEL = 3'd5
  } cfg_idx_t;

  // drive mode codes
  typedef enum logic [MODE_W-1:0] {
    DRV_LOW  = 2'd0,
    DRV_HIGH = 2'd1,
    DRV_PWM  = 2'd2
  } drive_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [TEMP_W-1:0] temp_top;
    logic [TEMP_W-1:0] temp_base;
    logic [DUTY_W-1:0] duty_full;
    logic [DUTY_W-1:0] duty_floor;
    logic              active_low;
    logic [CH_W-1:0]   fan_channel;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic up;
    logic dn;
    logic c1;
    logic c2;
    logic c3;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic echo;
    logic up_go;
    logic dn_go;
  } sts_t;

  // pwm step of each level
  function automatic logic [STEP_W-1:0] step_of(input logic [LVL_W-1:0] lvl);
    logic [STEP_W-1:0] s;
    case (lvl)
      4'd2:    s = 4'd4;
      4'd3:    s = 4'd4;
      4'd4:    s = 4'd5;
      4'd5:    s = 4'd5;
      4'd6:    s = 4'd6;
      4'd7:    s = 4'd7;
      4'd8:    s = 4'd6;
      4'd9:    s = 4'd3;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/fldc_ctrl.sv =====
`timescale 1ns / 1ps

module fldc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fldc_pkg::sts_t    sts,
  output fldc_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_UP   = 8'b0000_0100,
    S_DN   = 8'b0000_1000,
    S_C1   = 8'b0001_0000,
    S_C2   = 8'b0010_0000,
    S_C3   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // sequencing of one item and the output register flag
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.echo ? S_FIN : S_UP;
      end
      S_UP: begin
        if (sts.up_go) begin
          cmd.up = 1'b1;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_DN: begin
        if (sts.dn_go) begin
          cmd.dn = 1'b1;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        cmd.c1    = 1'b1;
        state_nxt = S_C2;
      end
      S_C2: begin
        cmd.c2    = 1'b1;
        state_nxt = S_C3;
      end
      S_C3: begin
        cmd.c3    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/fldc_dp.sv =====
`timescale 1ns / 1ps

module fldc_dp #(
  parameter int LEVEL_COUNT = fldc_pkg::LEVEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fldc_pkg::cfg_t                  cfg,
  input  fldc_pkg::cmd_t                  cmd,
  output fldc_pkg::sts_t                  sts,
  input  logic [fldc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic [fldc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]                      out_tuser
);

  localparam int LVL_W  = fldc_pkg::LVL_W;
  localparam int TEMP_W = fldc_pkg::TEMP_W;
  localparam int DUTY_W = fldc_pkg::DUTY_W;
  localparam int STEP_W = fldc_pkg::STEP_W;
  localparam int THR_W  = fldc_pkg::THR_W;
  localparam int ACC_W  = fldc_pkg::ACC_W;
  localparam int PROD_W = fldc_pkg::PROD_W;
  localparam int SPAN_W = 6;
  localparam int HALF_W = 5;
  localparam int TEN_W  = 5;
  localparam int TWN_W  = 4;
  localparam int MAG_W  = 9;
  localparam int DRAW_W = 10;

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVEL_COUNT - 1);
  // duty table breakpoints: tenth steps up to level six, fixed twentieths, full at level zero and from ten
  localparam logic [LVL_W-1:0] LVL_TENTH_END = 4'd6;
  localparam logic [LVL_W-1:0] LVL_TW_A      = 4'd7;
  localparam logic [LVL_W-1:0] LVL_TW_B      = 4'd8;
  localparam logic [LVL_W-1:0] LVL_FULL_FROM = 4'd10;
  localparam logic [DRAW_W-1:0] TW_MUL_A = 10'd13;
  localparam logic [DRAW_W-1:0] TW_MUL_B = 10'd16;
  localparam logic [DRAW_W-1:0] TW_MUL_C = 10'd19;

  // floor(m/10) and floor(m/20) for m up to 319, the widest that the result fields hold
  function automatic logic [TEN_W-1:0] div10(input logic [MAG_W-1:0] m);
    logic [PROD_W-1:0] p;
    p = PROD_W'(m) * PROD_W'(fldc_pkg::RECIP_TEN);
    return p[15:11];
  endfunction

  function automatic logic [TWN_W-1:0] div20(input logic [MAG_W-1:0] m);
    logic [PROD_W-1:0] p;
    p = PROD_W'(m) * PROD_W'(fldc_pkg::RECIP_TEN);
    return p[15:12];
  endfunction

  // level "on" point
  function automatic logic signed [THR_W-1:0] thr_on(
    input logic [LVL_W-1:0]         i,
    input logic signed [SPAN_W-1:0] sp,
    input logic signed [TEMP_W-1:0] base
  );
    logic signed [THR_W-1:0] k;
    logic signed [THR_W-1:0] spx;
    logic signed [THR_W-1:0] r;
    k   = THR_W'(signed'({1'b0, i})) - THR_W'(1);
    spx = THR_W'(sp);
    if (i == '0) begin
      r = fldc_pkg::ON_LVL0;
    end else if (i >= LVL_MAX) begin
      r = fldc_pkg::ON_TOP;
    end else begin
      r = spx * k + THR_W'(base);
    end
    return r;
  endfunction

  // level "off" point
  function automatic logic signed [THR_W-1:0] thr_off(
    input logic [LVL_W-1:0]         i,
    input logic signed [SPAN_W-1:0] sp,
    input logic signed [HALF_W-1:0] hf,
    input logic signed [TEMP_W-1:0] base
  );
    logic signed [THR_W-1:0] k;
    logic signed [THR_W-1:0] spx;
    logic signed [THR_W-1:0] r;
    k   = THR_W'(signed'({1'b0, i})) - THR_W'(2);
    spx = THR_W'(sp);
    if (i == '0) begin
      r = fldc_pkg::OFF_LVL0;
    end else if (i == LVL_W'(1)) begin
      r = fldc_pkg::OFF_LVL1;
    end else begin
      r = spx * k + THR_W'(base) - THR_W'(hf);
    end
    return r;
  endfunction

  // saturate a signed sum to 0..top
  function automatic logic [DUTY_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0] v,
    input logic [DUTY_W-1:0]       top
  );
    logic [DUTY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ACC_W'(signed'({1'b0, top}))) begin
      r = top;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  // item registers
  logic signed [TEMP_W-1:0] temp_r;
  logic [DUTY_W-1:0]        last_d_r;
  logic [LVL_W-1:0]         lvl_r;
  logic                     echo_r;
  logic signed [SPAN_W-1:0] span_r;
  logic signed [HALF_W-1:0] half_r;
  logic [TEN_W-1:0]         tenth_r;
  logic [TWN_W-1:0]         twen_r;
  logic [DUTY_W-1:0]        dcr0_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [THR_W-1:0]  on_r;
  logic signed [THR_W-1:0]  off_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic                     active_r;
  logic                     rising_r;
  logic [DUTY_W-1:0]        res_r;
  logic [fldc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                     out_user_r;

  // persistent state
  logic [LVL_W-1:0]         cur_lvl_r;
  logic signed [TEMP_W-1:0] prev_r;

  // load: hotter temperature, logical readback, starting level
  logic signed [TEMP_W-1:0] cpu_t, sys_t, temp_ld;
  logic [DUTY_W-1:0]        raw_t, last_d_ld;
  logic [LVL_W-1:0]         lvl_ld;

  always_comb begin
    cpu_t   = signed'(in_tdata[7:0]);
    sys_t   = signed'(in_tdata[15:8]);
    raw_t   = in_tdata[23:16];
    temp_ld = (cpu_t > sys_t) ? cpu_t : sys_t;
    if (cfg.active_low) begin
      last_d_ld = (raw_t > cfg.duty_full) ? '0 : cfg.duty_full - raw_t;
    end else begin
      last_d_ld = raw_t;
    end
    lvl_ld = (cur_lvl_r > LVL_MAX) ? LVL_MAX : cur_lvl_r;
  end

  // prep: table span, half window, duty tenth and twentieth
  logic signed [DRAW_W-1:0] d_span, d_half;
  logic [MAG_W-1:0]         m_span, m_half;
  logic [TEN_W-1:0]         q_span;
  logic [TWN_W-1:0]         q_half;
  logic signed [SPAN_W-1:0] span_p;
  logic signed [HALF_W-1:0] half_p;

  always_comb begin
    d_span = DRAW_W'(signed'(cfg.temp_top)) - DRAW_W'(signed'(cfg.temp_base)) + DRAW_W'(5);
    d_half = DRAW_W'(signed'(cfg.temp_top)) - DRAW_W'(signed'(cfg.temp_base)) + DRAW_W'(10);
    m_span = d_span[DRAW_W-1] ? MAG_W'(-d_span) : MAG_W'(d_span);
    m_half = d_half[DRAW_W-1] ? MAG_W'(-d_half) : MAG_W'(d_half);
    q_span = div10(m_span);
    q_half = div20(m_half);
    span_p = d_span[DRAW_W-1] ? -SPAN_W'(q_span) : SPAN_W'(q_span);
    half_p = d_half[DRAW_W-1] ? -HALF_W'(q_half) : HALF_W'(q_half);
  end

  // search status: threshold compares at the current level
  logic signed [THR_W-1:0] tx;
  logic signed [THR_W-1:0] on_cur, off_cur;

  always_comb begin
    tx        = THR_W'(temp_r);
    on_cur    = thr_on(lvl_r, span_r, signed'(cfg.temp_base));
    off_cur   = thr_off(lvl_r, span_r, half_r, signed'(cfg.temp_base));
    sts.echo  = (temp_r == prev_r);
    sts.up_go = (lvl_r < LVL_MAX) && (tx > on_cur);
    sts.dn_go = (lvl_r != '0) && (tx < off_cur);
  end

  // c1: table duty of the final level
  logic [DRAW_W-1:0] draw;
  logic [DRAW_W-1:0] lvl_m1;

  always_comb begin
    lvl_m1 = DRAW_W'(lvl_r) - DRAW_W'(1);
    if (lvl_r == '0 || lvl_r >= LVL_MAX || lvl_r >= LVL_FULL_FROM) begin
      draw = DRAW_W'(cfg.duty_full);
    end else if (lvl_r <= LVL_TENTH_END) begin
      draw = DRAW_W'(tenth_r) * lvl_m1 + DRAW_W'(cfg.duty_floor);
    end else if (lvl_r == LVL_TW_A) begin
      draw = DRAW_W'(twen_r) * TW_MUL_A + DRAW_W'(cfg.duty_floor);
    end else if (lvl_r == LVL_TW_B) begin
      draw = DRAW_W'(twen_r) * TW_MUL_B + DRAW_W'(cfg.duty_floor);
    end else begin
      draw = DRAW_W'(twen_r) * TW_MUL_C + DRAW_W'(cfg.duty_floor);
    end
  end

  // c2: offset factor times step
  logic signed [THR_W:0]   diff;
  logic signed [THR_W:0]   hw;
  logic signed [ACC_W-1:0] fac;
  logic signed [ACC_W-1:0] stp;
  logic                    rising_c;

  always_comb begin
    rising_c = (temp_r > prev_r);
    diff     = (THR_W + 1)'(on_r) - (THR_W + 1)'(off_r);
    hw       = diff >>> 1;
    fac      = ACC_W'(tx) - ACC_W'(off_r) + (rising_c ? ACC_W'(0) : ACC_W'(hw));
    stp      = ACC_W'(signed'({1'b0, step_r}));
  end

  // c3: saturate and hold against the current duty
  logic signed [ACC_W-1:0] sum;
  logic [DUTY_W-1:0]       c_sat;
  logic [DUTY_W-1:0]       c_adj;
  logic [DRAW_W-1:0]       up_sum;

  always_comb begin
    sum    = ACC_W'(signed'({1'b0, dcr0_r})) + prod_r;
    c_sat  = clamp_acc(sum, cfg.duty_full);
    up_sum = DRAW_W'(last_d_r) + DRAW_W'(step_r);
    c_adj  = c_sat;
    if (rising_r) begin
      if (c_sat < last_d_r) begin
        c_adj = (up_sum <= DRAW_W'(cfg.duty_full)) ? up_sum[DUTY_W-1:0] : cfg.duty_full;
      end
    end else if (c_sat > last_d_r) begin
      c_adj = last_d_r;
    end
  end

  // finish: drive mode and register value
  fldc_pkg::drive_t        mode;
  logic [DUTY_W-1:0]       reg_v;
  logic [STEP_W-1:0]       srate;
  logic                    sen;
  logic [fldc_pkg::OUT_DATA_W-1:0] res_word;

  always_comb begin
    mode  = fldc_pkg::DRV_PWM;
    reg_v = '0;
    srate = '0;
    sen   = 1'b0;
    if (res_r == '0) begin
      mode = fldc_pkg::DRV_LOW;
    end else if (res_r == cfg.duty_full) begin
      mode = fldc_pkg::DRV_HIGH;
    end else begin
      reg_v = cfg.active_low ? cfg.duty_full - res_r : res_r;
      srate = step_r;
      sen   = (step_r != '0);
    end
    if (echo_r) begin
      res_word = {2'b00, cfg.fan_channel, 1'b0, {DUTY_W{1'b0}}, fldc_pkg::DRV_LOW,
                  {STEP_W{1'b0}}, cur_lvl_r, last_d_r};
    end else begin
      res_word = {2'b00, cfg.fan_channel, sen, reg_v, mode, srate, lvl_r, res_r};
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r   <= temp_ld;
      last_d_r <= last_d_ld;
      lvl_r    <= lvl_ld;
    end
    if (cmd.prep) begin
      echo_r  <= sts.echo;
      span_r  <= span_p;
      half_r  <= half_p;
      tenth_r <= div10(MAG_W'(cfg.duty_full) + MAG_W'(5));
      twen_r  <= div20(MAG_W'(cfg.duty_full) + MAG_W'(10));
    end
    if (cmd.up) begin
      lvl_r <= lvl_r + LVL_W'(1);
    end
    if (cmd.dn) begin
      lvl_r <= lvl_r - LVL_W'(1);
    end
    if (cmd.c1) begin
      dcr0_r <= (draw > DRAW_W'(cfg.duty_full)) ? cfg.duty_full : draw[DUTY_W-1:0];
      step_r <= fldc_pkg::step_of(lvl_r);
      on_r   <= on_cur;
      off_r  <= off_cur;
    end
    if (cmd.c2) begin
      prod_r   <= fac * stp;
      rising_r <= rising_c;
      active_r <= (dcr0_r != '0) && (dcr0_r < cfg.duty_full);
    end
    if (cmd.c3) begin
      res_r <= active_r ? c_adj : dcr0_r;
    end
    if (cmd.fin) begin
      out_data_r <= res_word;
      out_user_r <= !echo_r;
    end
  end

  // level and last temperature, kept when the temperature is unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_lvl_r <= fldc_pkg::LEVEL_RST;
      prev_r    <= signed'(fldc_pkg::PREV_RST);
    end else if (cmd.fin && !echo_r) begin
      cur_lvl_r <= lvl_r;
      prev_r    <= temp_r;
    end
  end

  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

// ===== rtl/fan_level_duty_control.sv =====
`timescale 1ns / 1ps
// channel  side    handshake               payload
// in       slave   in_tvalid / in_tready   in_tdata[23:0]
// out      master  out_tvalid / out_tready out_tdata[31:0], out_tuser[0:0]
// cfg      slave   cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[7:0]
//
// an item with an unchanged temperature goes from load and prep straight to
// finish; otherwise the level search makes at most 2*(LEVEL_COUNT-1) moves, one
// level per cycle through the threshold compare, before steps c1, c2 and c3.
// reset is synchronous, active low: level 1, last temperature 127, config defaults.
// a result held in the output register stalls the next item only at its last step.
// cfg_ready is always high; writes land in the next cycle.

module fan_level_duty_control #(
  parameter int LEVEL_COUNT = fldc_pkg::LEVEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cpu_deg [7:0], sys_deg [15:8], duty_readback [23:16]
  input  logic [fldc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // new_duty [7:0], fan_level [11:8], step_rate [15:12], drive_mode [17:16],
  // duty_register [25:18], step_enable [26], target_channel [29:27], zero [31:30]
  output logic [fldc_pkg::OUT_DATA_W-1:0] out_tdata,
  // written [0]
  output logic [0:0]                      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fldc_pkg::CFG_DATA_W-1:0] cfg_data
);

  fldc_pkg::cfg_t cfg_r, cfg_nxt;
  fldc_pkg::cmd_t cmd;
  fldc_pkg::sts_t sts;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (fldc_pkg::cfg_idx_t'(cfg_index))
        fldc_pkg::CFG_TEMP_TOP:    cfg_nxt.temp_top    = cfg_data;
        fldc_pkg::CFG_TEMP_BASE:   cfg_nxt.temp_base   = cfg_data;
        fldc_pkg::CFG_DUTY_FULL:   cfg_nxt.duty_full   = cfg_data;
        fldc_pkg::CFG_DUTY_FLOOR:  cfg_nxt.duty_floor  = cfg_data;
        fldc_pkg::CFG_ACTIVE_LOW:  cfg_nxt.active_low  = cfg_data[0];
        fldc_pkg::CFG_FAN_CHANNEL: cfg_nxt.fan_channel = cfg_data[fldc_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_top    <= 8'd65;
      cfg_r.temp_base   <= 8'd20;
      cfg_r.duty_full   <= 8'd255;
      cfg_r.duty_floor  <= 8'd0;
      cfg_r.active_low  <= 1'b0;
      cfg_r.fan_channel <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer
  fldc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // level search and duty arithmetic
  fldc_dp #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // unchanged temperature leaves all drive fields clear
  a_echo_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[26:12] == '0)
    else $error("drive fields set on an unchanged-temperature result");

  // level stays within the table
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] <= fldc_pkg::LVL_W'(LEVEL_COUNT - 1))
    else $error("fan level beyond the table");

  // a computed duty never exceeds full speed
  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:0] <= cfg_r.duty_full)
    else $error("new duty above duty_full");

  // one item at a time: an accepted transaction closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input reopened right after a transaction");

endmodule

// ===== sim/fan_level_duty_control_test.sv =====
`timescale 1ns / 1ps

module fan_level_duty_control_test;

  localparam int LEVELS          = fldc_pkg::LEVEL_COUNT_DEF;
  localparam int STALL_LIMIT     = 6000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int RANDOM_PHASES   = 7;

  // one result transaction, fields as they sit in out_tdata / out_tuser
  typedef struct packed {
    logic [fldc_pkg::DUTY_W-1:0] new_duty;
    logic [fldc_pkg::LVL_W-1:0]  fan_level;
    logic [fldc_pkg::STEP_W-1:0] step_rate;
    fldc_pkg::drive_t            drive_mode;
    logic [fldc_pkg::DUTY_W-1:0] duty_register;
    logic                        step_enable;
    logic [fldc_pkg::CH_W-1:0]   target_channel;
    logic                        written;
  } fan_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic [fldc_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [fldc_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [0:0]                        out_tuser;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [fldc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [fldc_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // predictor copy of the registers and the state
  logic signed [fldc_pkg::TEMP_W-1:0] cfg_top = 8'sd65;
  logic signed [fldc_pkg::TEMP_W-1:0] cfg_base = 8'sd20;
  logic [fldc_pkg::DUTY_W-1:0]        cfg_full = 8'd255;
  logic [fldc_pkg::DUTY_W-1:0]        cfg_floor = 8'd0;
  logic                               cfg_act_low = 1'b0;
  logic [fldc_pkg::CH_W-1:0]          cfg_chan = '0;
  logic [fldc_pkg::LVL_W-1:0]         level_q = fldc_pkg::LEVEL_RST;
  logic signed [fldc_pkg::TEMP_W-1:0] prev_temp_q = fldc_pkg::PREV_RST;

  fan_result_t fan_results_q[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  logic        tx_idle_en = 1'b1;
  logic        rx_idle_en = 1'b1;
  logic        rx_hold = 1'b0;
  int          walk_temp = 20;
  logic [7:0]  readback_hint = 8'd0;

  fan_level_duty_control i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // level table of the predictor
  function automatic int clamp_duty(int d);
    int full;
    full = cfg_full;
    if (d < 0) return 0;
    if (d > full) return full;
    return d;
  endfunction

  function automatic int span_width();
    return (cfg_top - cfg_base + 5) / 10;
  endfunction

  function automatic int half_width();
    return (cfg_top - cfg_base + 10) / 20;
  endfunction

  function automatic int level_on(int i);
    int b;
    b = cfg_base;
    if (i == 0) return -35;
    if (i >= LEVELS - 1) return 127;
    return span_width() * (i - 1) + b;
  endfunction

  function automatic int level_off(int i);
    int b;
    b = cfg_base;
    if (i == 0) return -128;
    if (i == 1) return -40;
    return span_width() * (i - 2) + b - half_width();
  endfunction

  function automatic int level_duty(int i);
    int full, fl, tenth, twen, d;
    full = cfg_full;
    fl = cfg_floor;
    tenth = (full + 5) / 10;
    twen = (full + 10) / 20;
    if (i == 0 || i >= LEVELS - 1 || i >= 10) d = full;
    else if (i <= 6) d = tenth * (i - 1) + fl;
    else if (i == 7) d = twen * 13 + fl;
    else if (i == 8) d = twen * 16 + fl;
    else d = twen * 19 + fl;
    return clamp_duty(d);
  endfunction

  function automatic int step_for_level(int i);
    case (i)
      2, 3:    return 4;
      4, 5:    return 5;
      6, 8:    return 6;
      7:       return 7;
      9:       return 3;
      default: return 0;
    endcase
  endfunction

  // expected result of one reading; advances level and last temperature
  function automatic fan_result_t predict_fan(logic [7:0] cpu, logic [7:0] sys,
                                              logic [7:0] raw);
    fan_result_t r;
    int c, s, t, last_t, full, rawv, last_d, lvl, d, step, diff, hw;
    c = $signed(cpu);
    s = $signed(sys);
    t = (c > s) ? c : s;
    last_t = prev_temp_q;
    full = cfg_full;
    rawv = raw;
    if (cfg_act_low) last_d = (rawv > full) ? 0 : full - rawv;
    else last_d = rawv;
    r = '0;
    r.target_channel = cfg_chan;

    // unchanged temperature: echo only, state kept
    if (t == last_t) begin
      r.new_duty = last_d[7:0];
      r.fan_level = level_q;
      return r;
    end

    // hysteresis search: climb on the on points, then fall on the off points
    lvl = level_q;
    if (lvl > LEVELS - 1) lvl = LEVELS - 1;
    while (lvl < LEVELS - 1 && t > level_on(lvl)) lvl++;
    while (lvl > 0 && t < level_off(lvl)) lvl--;

    d = level_duty(lvl);
    step = step_for_level(lvl);
    if (d != 0 && d < full) begin
      if (t > last_t) begin
        d = clamp_duty(d + (t - level_off(lvl)) * step);
        if (d < last_d) d = (last_d <= full - step) ? last_d + step : full;
      end else begin
        diff = level_on(lvl) - level_off(lvl);
        hw = (diff >= 0) ? diff / 2 : -((1 - diff) / 2);
        d = clamp_duty(d + (t + hw - level_off(lvl)) * step);
        if (d > last_d) d = last_d;
      end
    end
    d = clamp_duty(d);

    r.new_duty = d[7:0];
    r.fan_level = lvl[3:0];
    r.written = 1'b1;
    if (d == 0) r.drive_mode = fldc_pkg::DRV_LOW;
    else if (d == full) r.drive_mode = fldc_pkg::DRV_HIGH;
    else begin
      r.drive_mode = fldc_pkg::DRV_PWM;
      r.duty_register = cfg_act_low ? 8'(full - d) : d[7:0];
      r.step_rate = step[3:0];
      r.step_enable = (step != 0);
    end
    level_q = lvl[3:0];
    prev_temp_q = t[7:0];
    return r;
  endfunction

  // result side: check each transaction, then pick the next ready
  always @(posedge clk) begin
    fan_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.new_duty       = out_tdata[7:0];
      got.fan_level      = out_tdata[11:8];
      got.step_rate      = out_tdata[15:12];
      got.drive_mode     = fldc_pkg::drive_t'(out_tdata[17:16]);
      got.duty_register  = out_tdata[25:18];
      got.step_enable    = out_tdata[26];
      got.target_channel = out_tdata[29:27];
      got.written        = out_tuser[0];
      if (fan_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: tdata %h tuser %b", out_tdata, out_tuser);
      end else begin
        exp_r = fan_results_q.pop_front();
        if (got.new_duty !== exp_r.new_duty || got.fan_level !== exp_r.fan_level ||
            got.step_rate !== exp_r.step_rate || got.drive_mode !== exp_r.drive_mode ||
            got.duty_register !== exp_r.duty_register ||
            got.step_enable !== exp_r.step_enable ||
            got.target_channel !== exp_r.target_channel ||
            got.written !== exp_r.written) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"mismatch expected: duty %0d level %0d step %0d mode %0d",
                      " reg %0d en %0b ch %0d wr %0b"},
                     exp_r.new_duty, exp_r.fan_level, exp_r.step_rate, exp_r.drive_mode,
                     exp_r.duty_register, exp_r.step_enable, exp_r.target_channel,
                     exp_r.written);
            $display({"         actual:   duty %0d level %0d step %0d mode %0d",
                      " reg %0d en %0b ch %0d wr %0b"},
                     got.new_duty, got.fan_level, got.step_rate, got.drive_mode,
                     got.duty_register, got.step_enable, got.target_channel, got.written);
          end
        end
      end
    end
    if (!rst_n || rx_hold) out_tready <= 1'b0;
    else if (rx_idle_en && $urandom_range(99) < 27) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // one reading transaction, with an occasional random gap before it
  task automatic send_reading(input logic [7:0] cpu, input logic [7:0] sys,
                              input logic [7:0] raw);
    fan_result_t r;
    if (tx_idle_en && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 27);
      if ($urandom_range(99) < 5) repeat ($urandom_range(10, 40)) @(posedge clk);
    end
    in_tdata <= {raw, sys, cpu};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = predict_fan(cpu, sys, raw);
    fan_results_q.push_back(r);
    // what a driver would read back next time
    readback_hint = cfg_act_low ? 8'(cfg_full - r.new_duty) : r.new_duty;
  endtask

  // mostly a slow temperature walk, some repeats, some jumps and noise
  task automatic send_random_reading();
    int pick, t, other;
    logic [7:0] cpu, sys, raw;
    pick = $urandom_range(99);
    if (pick < 10) t = prev_temp_q;
    else if (pick < 75) t = walk_temp + $urandom_range(12) - 6;
    else t = $urandom_range(255) - 128;
    if (t > 127) t = 127;
    if (t < -128) t = -128;
    walk_temp = t;
    other = $urandom_range(t + 128) - 128;
    if (pick >= 90) begin
      cpu = 8'($urandom);
      sys = 8'($urandom);
    end else if ($urandom_range(1)) begin
      cpu = t[7:0];
      sys = other[7:0];
    end else begin
      cpu = other[7:0];
      sys = t[7:0];
    end
    raw = ($urandom_range(99) < 70) ? readback_hint : 8'($urandom);
    send_reading(cpu, sys, raw);
  endtask

  task automatic write_reg(input fldc_pkg::cfg_idx_t idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fldc_pkg::CFG_TEMP_TOP:    cfg_top = val;
      fldc_pkg::CFG_TEMP_BASE:   cfg_base = val;
      fldc_pkg::CFG_DUTY_FULL:   cfg_full = val;
      fldc_pkg::CFG_DUTY_FLOOR:  cfg_floor = val;
      fldc_pkg::CFG_ACTIVE_LOW:  cfg_act_low = val[0];
      fldc_pkg::CFG_FAN_CHANNEL: cfg_chan = val[2:0];
      default: ;
    endcase
  endtask

  // stop sending and wait until every expected result is out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (fan_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] top, input logic [7:0] base,
                                input logic [7:0] full, input logic [7:0] floor_duty,
                                input logic act_low, input logic [2:0] chan);
    drain_results();
    write_reg(fldc_pkg::CFG_TEMP_TOP, top);
    write_reg(fldc_pkg::CFG_TEMP_BASE, base);
    write_reg(fldc_pkg::CFG_DUTY_FULL, full);
    write_reg(fldc_pkg::CFG_DUTY_FLOOR, floor_duty);
    write_reg(fldc_pkg::CFG_ACTIVE_LOW, {7'd0, act_low});
    write_reg(fldc_pkg::CFG_FAN_CHANNEL, {5'd0, chan});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // last temperature after reset is 127: unchanged readings echo the readback
  task automatic test_unchanged_echo();
    send_reading(8'sd127, 8'h80, 8'h00);
    send_reading(8'h80, 8'sd127, 8'hff);
  endtask

  // walk down to level 0, up to the top level and back down
  task automatic test_level_sweep();
    int sweep_temps [15];
    sweep_temps = '{-128, -36, -34, 20, 21, 50, 64, 65, 66, 127, 60, 30, 0, -50, -128};
    for (int i = 0; i < 15; i++) begin
      if (i % 2) send_reading(8'h80, sweep_temps[i][7:0], readback_hint);
      else send_reading(sweep_temps[i][7:0], 8'h80, readback_hint);
    end
  endtask

  // inverted drive, readback above full scale
  task automatic test_active_low_readback();
    apply_settings(8'd90, 8'd30, 8'd200, 8'd30, 1'b1, 3'd5);
    send_reading(8'd60, -8'sd10, 8'd250);
    send_reading(8'd40, 8'd40, 8'd0);
    send_reading(8'd40, 8'd12, 8'd201);
    send_reading(8'd80, 8'd0, 8'd200);
  endtask

  // top below base, floor above full
  task automatic test_odd_registers();
    apply_settings(-8'sd100, 8'd100, 8'd50, 8'd200, 1'b0, 3'd6);
    send_reading(8'd0, 8'h55, 8'haa);
    send_reading(8'd120, 8'd3, 8'h55);
  endtask

  // receiver holds off for a long stretch while readings keep coming
  task automatic test_backpressure();
    apply_settings(8'd65, 8'd20, 8'd255, 8'd0, 1'b0, 3'd2);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (16) send_random_reading();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings(8'd65, 8'd20, 8'd255, 8'd0, 1'b0, 3'd0);
        1: apply_settings(8'd127, 8'h80, 8'd255, 8'd0, 1'b0, 3'd7);
        2: apply_settings(8'h80, 8'd127, 8'd1, 8'd255, 1'b1, 3'd0);
        3: apply_settings(8'd80, 8'd40, 8'd100, 8'd10, 1'b1, 3'd3);
        default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
                                8'($urandom), 1'($urandom_range(1)),
                                3'($urandom_range(7)));
      endcase
      // one phase runs with both sides always ready
      tx_idle_en = (p != 3);
      rx_idle_en <= (p != 3);
      walk_temp = prev_temp_q;
      repeat (ITEMS_PER_PHASE) send_random_reading();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unchanged_echo();
    test_level_sweep();
    test_active_low_readback();
    test_odd_registers();
    test_backpressure();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0 && fan_results_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
